/* rtl/bvpi_pkg.sv */
// Shared types and codes for the bounded vector core.
// No dependencies; imported by bvpi_ctrl and bounded_vector_push_pop_insert_core.
`default_nettype none
package bvpi_pkg;

    localparam int KIND_W   = 2;
    localparam int POS_W    = 4;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [KIND_W-1:0] KIND_PUSH   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

    // Result word handed from the sequencer to the output register.
    typedef struct packed {
        logic [DATA_W-1:0]   data_out;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count_after;
    } t_res;

endpackage
`default_nettype wire

/* rtl/bvpi_mem.sv */
// Element storage: one write port, one read port with registered data.
// No package dependencies.
`default_nettype none
module bvpi_mem #(
    parameter int DEPTH         = 16,
    parameter int ELEMENT_WIDTH = 32,
    parameter int AW            = 4
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [AW-1:0]            i_waddr,
    input  wire logic [ELEMENT_WIDTH-1:0] i_wdata,
    input  wire logic                     i_re,
    input  wire logic [AW-1:0]            i_raddr,
    output logic      [ELEMENT_WIDTH-1:0] o_rdata
);

    logic [ELEMENT_WIDTH-1:0] r_mem [DEPTH];
    logic [ELEMENT_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Hold read data until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* rtl/bvpi_ctrl.sv */
// Sequencer: decodes one operation, tracks the fill count and moves
// elements up one slot per step through the storage ports. Uses bvpi_pkg.
`default_nettype none
module bvpi_ctrl #(
    parameter int DEPTH         = 16,
    parameter int ELEMENT_WIDTH = 32,
    parameter int AW            = 4
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [bvpi_pkg::KIND_W-1:0]   i_kind,
    input  wire logic [bvpi_pkg::POS_W-1:0]    i_position,
    input  wire logic [bvpi_pkg::DATA_W-1:0]   i_data_in,
    output logic                               o_res_valid,
    output bvpi_pkg::t_res                     o_res,
    input  wire logic                          i_res_take,
    output logic                               o_we,
    output logic [AW-1:0]                      o_waddr,
    output logic [ELEMENT_WIDTH-1:0]           o_wdata,
    output logic                               o_re,
    output logic [AW-1:0]                      o_raddr,
    input  wire logic [ELEMENT_WIDTH-1:0]      i_rdata
);
    import bvpi_pkg::*;

    localparam int CW  = $clog2(DEPTH + 1);
    localparam int EXW = (ELEMENT_WIDTH > DATA_W) ? ELEMENT_WIDTH : DATA_W;
    localparam int PXW = (AW > POS_W) ? AW : POS_W;
    localparam int CXW = (CW > COUNT_W) ? CW : COUNT_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_WR   = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]               r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic [AW-1:0]            r_idx, n_idx;
    logic [AW-1:0]            r_pos, n_pos;
    logic [ELEMENT_WIDTH-1:0] r_val, n_val;
    logic [STATUS_W-1:0]      r_status, n_status;
    logic                     r_use_rd, n_use_rd;

    logic                     w_accept;
    logic                     w_full;
    logic                     w_empty;
    logic                     w_badpos;
    logic [EXW-1:0]           w_din_ext;
    logic [EXW-1:0]           w_rd_ext;
    logic [PXW-1:0]           w_pos_ext;
    logic [CXW-1:0]           w_cnt_ext;
    logic [AW-1:0]            w_tail;
    logic [AW-1:0]            w_idx_dn;

    assign w_accept  = i_in_valid && (r_state == S_IDLE);
    assign w_full    = (r_count == CW'(DEPTH));
    assign w_empty   = (r_count == '0);
    assign w_badpos  = (32'(i_position) >= 32'(r_count));
    assign w_din_ext = EXW'(i_data_in);
    assign w_rd_ext  = EXW'(i_rdata);
    assign w_pos_ext = PXW'(i_position);
    assign w_cnt_ext = CXW'(r_count);
    assign w_tail    = r_count[AW-1:0];
    assign w_idx_dn  = r_idx - AW'(1);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_pos    = r_pos;
        n_val    = r_val;
        n_status = r_status;
        n_use_rd = r_use_rd;
        o_we     = 1'b0;
        o_waddr  = w_tail;
        o_wdata  = w_din_ext[ELEMENT_WIDTH-1:0];
        o_re     = 1'b0;
        o_raddr  = w_tail - AW'(1);

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_status = ST_OK;
                    n_use_rd = 1'b0;
                    n_state  = S_DONE;
                    n_val    = w_din_ext[ELEMENT_WIDTH-1:0];
                    n_pos    = w_pos_ext[AW-1:0];
                    n_idx    = w_tail;
                    unique case (i_kind)
                        KIND_PUSH: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                o_we    = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                        KIND_POP: begin
                            if (w_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                o_re     = 1'b1;
                                n_use_rd = 1'b1;
                                n_count  = r_count - CW'(1);
                            end
                        end
                        KIND_INSERT: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else if (w_badpos) begin
                                n_status = ST_BADPOS;
                            end else begin
                                n_count = r_count + CW'(1);
                                n_state = S_RD;
                            end
                        end
                        KIND_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_RD: begin
                // Fetch the element just below the slot being filled.
                o_re    = 1'b1;
                o_raddr = w_idx_dn;
                n_state = S_WR;
            end
            S_WR: begin
                o_we    = 1'b1;
                o_waddr = r_idx;
                o_wdata = i_rdata;
                n_idx   = w_idx_dn;
                n_state = (w_idx_dn == r_pos) ? S_FIN : S_RD;
            end
            S_FIN: begin
                o_we    = 1'b1;
                o_waddr = r_pos;
                o_wdata = r_val;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_status <= n_status;
        r_use_rd <= n_use_rd;
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_res_valid       = (r_state == S_DONE);
    assign o_res.data_out    = r_use_rd ? w_rd_ext[DATA_W-1:0] : '0;
    assign o_res.status      = r_status;
    assign o_res.count_after = w_cnt_ext[COUNT_W-1:0];

endmodule
`default_nettype wire

/* rtl/bounded_vector_push_pop_insert_core.sv */
// Top level of the bounded vector: sequencer, element storage and the
// output register. Uses bvpi_pkg, bvpi_ctrl and bvpi_mem.
//
// A vector of up to DEPTH elements with push, pop, insert-at-position and
// clear. One operation is taken at a time: o_in_stall stays high from
// acceptance until the result word moves into the output register. Push,
// pop, clear and every rejected operation go from acceptance straight to
// the sequencer's done state, from which the result word is loaded into
// the output register. An insert moves each element from the insert point
// upward by one slot through the one read port and one write port of the
// storage, a read state then a write state per element, then writes the
// new element in a final state before the done state. The output register
// frees the sequencer, so the next word is taken while a result still waits
// downstream; while that register holds a stalled word, a finished result
// waits in the sequencer's done state and o_in_stall stays high.
// Slot contents are not reset; clear only zeroes the count.
`default_nettype none
module bounded_vector_push_pop_insert_core #(
    parameter int DEPTH         = 16,
    parameter int ELEMENT_WIDTH = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [bvpi_pkg::KIND_W-1:0]       i_kind,
    input  wire logic [bvpi_pkg::POS_W-1:0]        i_position,
    input  wire logic [bvpi_pkg::DATA_W-1:0]       i_data_in,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [bvpi_pkg::DATA_W-1:0]            o_data_out,
    output logic [bvpi_pkg::STATUS_W-1:0]          o_status,
    output logic [bvpi_pkg::COUNT_W-1:0]           o_count_after
);
    import bvpi_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                     w_we;
    logic [AW-1:0]            w_waddr;
    logic [ELEMENT_WIDTH-1:0] w_wdata;
    logic                     w_re;
    logic [AW-1:0]            w_raddr;
    logic [ELEMENT_WIDTH-1:0] w_rdata;
    logic                     w_res_valid;
    t_res                     w_res;
    logic                     w_take;

    logic                     r_out_valid;
    t_res                     r_out;

    bvpi_ctrl #(
        .DEPTH         (DEPTH),
        .ELEMENT_WIDTH (ELEMENT_WIDTH),
        .AW            (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .i_position  (i_position),
        .i_data_in   (i_data_in),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_take  (w_take),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_re        (w_re),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata)
    );

    bvpi_mem #(
        .DEPTH         (DEPTH),
        .ELEMENT_WIDTH (ELEMENT_WIDTH),
        .AW            (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Load a new word when the output register is empty or draining.
    assign w_take = w_res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_data_out    = r_out.data_out;
    assign o_status      = r_out.status;
    assign o_count_after = r_out.count_after;

endmodule
`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 100ps
// Testbench for bounded_vector_push_pop_insert_core: a queue-fed driver and a
// clocked monitor check each result word against a behavioral vector model.
// Depends on bvpi_pkg and the core RTL only.
module testbench;
    import bvpi_pkg::*;

    localparam int VEC_DEPTH   = 16;
    localparam int RAND_OPS    = 1400;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] data;
        int unsigned       gap;
        bit                drain;
    } vec_op_t;

    typedef struct packed {
        logic [DATA_W-1:0]   data_out;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count_after;
    } vec_res_t;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_in_valid    = 1'b0;
    logic [KIND_W-1:0]   i_kind        = '0;
    logic [POS_W-1:0]    i_position    = '0;
    logic [DATA_W-1:0]   i_data_in     = '0;
    logic                i_out_stall   = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    logic [DATA_W-1:0]   o_data_out;
    logic [STATUS_W-1:0] o_status;
    logic [COUNT_W-1:0]  o_count_after;

    vec_op_t     pend_q[$];
    vec_res_t    expect_q[$];
    logic [DATA_W-1:0] model_slots [VEC_DEPTH];
    int unsigned model_len    = 0;
    int unsigned err_count    = 0;
    int unsigned cycle_cnt    = 0;
    int unsigned gap_cnt      = 0;
    int unsigned stall_left   = 0;
    int unsigned stall_pct    = 0;
    bit          word_taken   = 1'b0;

    // stimulus generation state
    int unsigned gen_len      = 0;
    int unsigned gap_mode     = 0;
    bit          drain_next   = 1'b0;

    bounded_vector_push_pop_insert_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_position    (i_position),
        .i_data_in     (i_data_in),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_data_out    (o_data_out),
        .o_status      (o_status),
        .o_count_after (o_count_after)
    );

    always #4 i_clk = ~i_clk;

    // Mostly short idle runs, now and then a long one.
    function automatic int unsigned pick_gap();
        if ($urandom_range(99) < 85) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(40, 10);
    endfunction

    // Apply one operation to the vector model and return the result word.
    function automatic vec_res_t apply_vector_op(logic [KIND_W-1:0] kind,
                                                 logic [POS_W-1:0] pos,
                                                 logic [DATA_W-1:0] data);
        vec_res_t r;
        int unsigned i;
        r.data_out = '0;
        r.status   = ST_OK;
        case (kind)
            KIND_PUSH: begin
                if (model_len >= VEC_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    model_slots[model_len] = data;
                    model_len = model_len + 1;
                end
            end
            KIND_POP: begin
                if (model_len == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.data_out = model_slots[model_len-1];
                    model_len = model_len - 1;
                end
            end
            KIND_INSERT: begin
                if (model_len >= VEC_DEPTH) begin
                    r.status = ST_FULL;
                end else if (pos >= model_len) begin
                    r.status = ST_BADPOS;
                end else begin
                    for (i = model_len; i > pos; i--) begin
                        model_slots[i] = model_slots[i-1];
                    end
                    model_slots[pos] = data;
                    model_len = model_len + 1;
                end
            end
            default: begin
                model_len = 0;
            end
        endcase
        r.count_after = model_len[COUNT_W-1:0];
        return r;
    endfunction

    task automatic flag_error(string msg);
        if (err_count < MAX_REPORTS) begin
            $display("ERROR at cycle %0d: %s", cycle_cnt, msg);
        end
        err_count++;
    endtask

    // Queue one word; the shadow length keeps insert positions mostly legal.
    task automatic add_op(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                          logic [DATA_W-1:0] data);
        vec_op_t op;
        op.kind  = kind;
        op.pos   = pos;
        op.data  = data;
        op.drain = drain_next;
        op.gap   = 0;
        if (gap_mode == 1 && $urandom_range(99) < 30) begin
            op.gap = pick_gap();
        end else if (gap_mode == 2 && $urandom_range(99) < 70) begin
            op.gap = pick_gap();
        end
        drain_next = 1'b0;
        pend_q.push_back(op);
        case (kind)
            KIND_PUSH:   if (gen_len < VEC_DEPTH) gen_len++;
            KIND_POP:    if (gen_len > 0) gen_len--;
            KIND_INSERT: if (gen_len < VEC_DEPTH && pos < gen_len) gen_len++;
            default:     gen_len = 0;
        endcase
    endtask

    task automatic add_random_op(int unsigned bias);
        int unsigned r;
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] data;
        r = $urandom_range(99);
        if (r < 3) begin
            kind = KIND_CLEAR;
        end else if (r < (bias == 0 ? 55 : bias == 1 ? 25 : 40)) begin
            kind = KIND_PUSH;
        end else if (r < (bias == 0 ? 80 : bias == 1 ? 40 : 65)) begin
            kind = KIND_INSERT;
        end else begin
            kind = KIND_POP;
        end
        if (gen_len > 0 && $urandom_range(9) < 8) begin
            pos = POS_W'($urandom_range(gen_len - 1));
        end else begin
            pos = POS_W'($urandom_range(VEC_DEPTH - 1));
        end
        case ($urandom_range(15))
            0:       data = '0;
            1:       data = '1;
            default: data = $urandom;
        endcase
        add_op(kind, pos, data);
    endtask

    // Output side: check the oldest expectation, then record the accepted word.
    always @(posedge i_clk) begin
        vec_res_t exp_r;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expect_q.size() == 0) begin
                    flag_error($sformatf("unexpected result data=%h status=%0d count=%0d",
                                         o_data_out, o_status, o_count_after));
                end else begin
                    exp_r = expect_q.pop_front();
                    if (o_data_out !== exp_r.data_out || o_status !== exp_r.status ||
                        o_count_after !== exp_r.count_after) begin
                        flag_error($sformatf(
                            "expected data=%h status=%0d count=%0d, got data=%h status=%0d count=%0d",
                            exp_r.data_out, exp_r.status, exp_r.count_after,
                            o_data_out, o_status, o_count_after));
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                expect_q.push_back(apply_vector_op(i_kind, i_position, i_data_in));
            end
            word_taken <= i_in_valid && !o_in_stall;
        end else begin
            word_taken <= 1'b0;
        end
    end

    // Input side: advance to the next word once the current one is taken.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || word_taken)) begin
            if (pend_q.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (gap_cnt < pend_q[0].gap) begin
                gap_cnt    <= gap_cnt + 1;
                i_in_valid <= 1'b0;
            end else if (pend_q[0].drain && expect_q.size() != 0) begin
                // hold off until every outstanding result has come back
                i_in_valid <= 1'b0;
            end else begin
                i_in_valid <= 1'b1;
                i_kind     <= pend_q[0].kind;
                i_position <= pend_q[0].pos;
                i_data_in  <= pend_q[0].data;
                gap_cnt    <= 0;
                pend_q.pop_front();
            end
        end
    end

    // Downstream stalls; the stall rate is re-chosen whenever the cycle counter is a multiple of 256.
    always @(negedge i_clk) begin
        if (cycle_cnt % 256 == 0) begin
            case ($urandom_range(2))
                0:       stall_pct <= 0;
                1:       stall_pct <= 10;
                default: stall_pct <= 40;
            endcase
        end
        if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
            stall_left  <= pick_gap() - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    initial begin
        int unsigned n;
        int unsigned bias;

        // empty vector: pop, insert and clear
        add_op(KIND_POP, 4'd0, 32'h1234_5678);
        add_op(KIND_INSERT, 4'd0, 32'hdead_beef);
        add_op(KIND_CLEAR, 4'd15, '1);
        add_op(KIND_PUSH, 4'd0, '0);
        add_op(KIND_PUSH, 4'd15, '1);
        add_op(KIND_INSERT, 4'd0, 32'ha5a5_a5a5);
        add_op(KIND_INSERT, 4'd2, 32'h5a5a_5a5a);
        // position equal to the length, then far past it
        add_op(KIND_INSERT, 4'd4, 32'h0bad_0bad);
        add_op(KIND_INSERT, 4'd15, 32'h0bad_0bad);
        add_op(KIND_POP, 4'd0, '0);
        for (n = 0; n < 12; n++) begin
            add_op(KIND_PUSH, 4'(n), $urandom);
        end
        add_op(KIND_INSERT, 4'd14, 32'hffff_0000);
        drain_next = 1'b1;
        add_op(KIND_PUSH, 4'd0, 32'h0000_ffff);
        // full vector: insert at the top position and at zero both report full
        add_op(KIND_INSERT, 4'd15, 32'h1111_1111);
        add_op(KIND_INSERT, 4'd0, 32'h2222_2222);
        add_op(KIND_POP, 4'd0, '0);
        add_op(KIND_CLEAR, 4'd0, '0);

        bias = 2;
        for (n = 0; n < RAND_OPS; n++) begin
            if (n % 100 == 0) begin
                gap_mode = $urandom_range(2);
                bias     = $urandom_range(2);
            end
            if (n % 350 == 175) begin
                drain_next = 1'b1;
            end
            add_random_op(bias);
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pend_q.size() != 0 || i_in_valid || expect_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (40) @(negedge i_clk);
        if (err_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
